// ----- src/clst_pkg.sv -----
// Shared types and codes for the circular list store.
package clst_pkg;

  typedef enum logic [2:0] {
    CMD_PREPEND   = 3'd0,
    CMD_APPEND    = 3'd1,
    CMD_DROP_HEAD = 3'd2,
    CMD_DROP_TAIL = 3'd3,
    CMD_INSERT_AT = 3'd4,
    CMD_ERASE_AT  = 3'd5,
    CMD_READ_AT   = 3'd6,
    CMD_CLEAR     = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    K_NONE,
    K_ADD,
    K_REM,
    K_READ
  } kind_e;

  typedef enum logic [1:0] {
    E_FRONT,
    E_BACK,
    E_MID
  } end_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_WALK_REQ,
    S_WALK,
    S_ADD1,
    S_ADD2,
    S_REM_A,
    S_REM_B,
    S_REM_C,
    S_RD1,
    S_RD2,
    S_CLR,
    S_FIN
  } state_e;

  typedef struct packed {
    logic    valid;
    status_e status;
  } res_ctrl_t;

endpackage

// ----- src/clst_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
module clst_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/clst_seq.sv -----
// Command sequencer: node memories, list pointers and the link-chain walker.
module clst_seq #(
  parameter int CAPACITY = 64,
  parameter int WORD_BITS = 32,
  localparam int SLOT_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              command_i,
  input  logic [CNT_W-1:0]        position_i,
  input  logic [WORD_BITS-1:0]    data_value_i,
  input  logic                    res_take_i,
  output clst_pkg::res_ctrl_t     res_ctrl_o,
  output logic [WORD_BITS-1:0]    res_value_o,
  output logic [WORD_BITS-1:0]    res_front_o,
  output logic [WORD_BITS-1:0]    res_back_o,
  output logic [CNT_W-1:0]        res_count_o,
  output logic                    res_empty_o
);

  clst_pkg::state_e  state_q, state_d;
  clst_pkg::kind_e   kind_q;
  clst_pkg::end_e    end_q;
  clst_pkg::status_e status_q;

  logic [WORD_BITS-1:0] data_q, value_q, front_q, back_q;
  logic [SLOT_W-1:0]    head_q, tail_q, free_q, cur_q, prev_q, slot_q, nxt_q, init_q;
  logic [CNT_W-1:0]     count_q, steps_q;

  // memory ports
  logic                 link_we;
  logic [SLOT_W-1:0]    link_waddr, link_wdata, link_raddr, link_rdata;
  logic                 word_we;
  logic [SLOT_W-1:0]    word_raddr;
  logic [WORD_BITS-1:0] word_rdata;

  // command decode
  clst_pkg::cmd_e    cmd;
  clst_pkg::status_e dec_status;
  clst_pkg::kind_e   dec_kind;
  clst_pkg::end_e    dec_end;
  clst_pkg::state_e  dec_next, post_walk;
  logic [CNT_W-1:0]  dec_steps;
  logic [SLOT_W-1:0] dec_slot, rem_slot;
  logic              accept, is_empty, is_full, is_single, init_last;

  assign cmd       = clst_pkg::cmd_e'(command_i);
  assign accept    = in_valid_i && (state_q == clst_pkg::S_IDLE);
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CNT_W'(CAPACITY));
  assign is_single = (count_q == CNT_W'(1));
  assign init_last = (init_q == SLOT_W'(CAPACITY - 1));
  assign rem_slot  = (end_q == clst_pkg::E_MID) ? cur_q : slot_q;

  always_comb begin
    unique case (kind_q)
      clst_pkg::K_ADD: post_walk = clst_pkg::S_ADD1;
      clst_pkg::K_REM: post_walk = clst_pkg::S_REM_A;
      default:         post_walk = clst_pkg::S_RD1;
    endcase
  end

  always_comb begin
    dec_status = clst_pkg::ST_OK;
    dec_kind   = clst_pkg::K_NONE;
    dec_end    = clst_pkg::E_FRONT;
    dec_next   = clst_pkg::S_FIN;
    dec_steps  = position_i;
    dec_slot   = free_q;
    unique case (cmd)
      clst_pkg::CMD_PREPEND, clst_pkg::CMD_APPEND: begin
        if (is_full) begin
          dec_status = clst_pkg::ST_FULL;
        end else begin
          dec_kind = clst_pkg::K_ADD;
          dec_end  = (cmd == clst_pkg::CMD_PREPEND) ? clst_pkg::E_FRONT : clst_pkg::E_BACK;
          dec_next = clst_pkg::S_ADD1;
        end
      end
      clst_pkg::CMD_DROP_HEAD: begin
        if (is_empty) begin
          dec_status = clst_pkg::ST_EMPTY;
        end else begin
          dec_kind = clst_pkg::K_REM;
          dec_slot = head_q;
          dec_next = is_single ? clst_pkg::S_REM_C : clst_pkg::S_REM_A;
        end
      end
      clst_pkg::CMD_DROP_TAIL: begin
        if (is_empty) begin
          dec_status = clst_pkg::ST_EMPTY;
        end else begin
          dec_kind  = clst_pkg::K_REM;
          dec_end   = clst_pkg::E_BACK;
          dec_slot  = tail_q;
          dec_steps = count_q - CNT_W'(1);
          dec_next  = is_single ? clst_pkg::S_REM_C : clst_pkg::S_WALK_REQ;
        end
      end
      clst_pkg::CMD_INSERT_AT: begin
        if (position_i > count_q) begin
          dec_status = clst_pkg::ST_RANGE;
        end else if (is_full) begin
          dec_status = clst_pkg::ST_FULL;
        end else begin
          dec_kind = clst_pkg::K_ADD;
          if (position_i == '0) begin
            dec_next = clst_pkg::S_ADD1;
          end else if (position_i == count_q) begin
            dec_end  = clst_pkg::E_BACK;
            dec_next = clst_pkg::S_ADD1;
          end else begin
            dec_end  = clst_pkg::E_MID;
            dec_next = clst_pkg::S_WALK_REQ;
          end
        end
      end
      clst_pkg::CMD_ERASE_AT: begin
        if (is_empty) begin
          dec_status = clst_pkg::ST_EMPTY;
        end else if (position_i >= count_q) begin
          dec_status = clst_pkg::ST_RANGE;
        end else begin
          dec_kind = clst_pkg::K_REM;
          if (position_i == '0) begin
            dec_slot = head_q;
            dec_next = is_single ? clst_pkg::S_REM_C : clst_pkg::S_REM_A;
          end else if (position_i == count_q - CNT_W'(1)) begin
            dec_end   = clst_pkg::E_BACK;
            dec_slot  = tail_q;
            dec_steps = count_q - CNT_W'(1);
            dec_next  = clst_pkg::S_WALK_REQ;
          end else begin
            dec_end  = clst_pkg::E_MID;
            dec_next = clst_pkg::S_WALK_REQ;
          end
        end
      end
      clst_pkg::CMD_READ_AT: begin
        if (is_empty) begin
          dec_status = clst_pkg::ST_EMPTY;
        end else if (position_i >= count_q) begin
          dec_status = clst_pkg::ST_RANGE;
        end else begin
          dec_kind = clst_pkg::K_READ;
          dec_next = clst_pkg::S_WALK_REQ;
        end
      end
      clst_pkg::CMD_CLEAR: begin
        dec_next = clst_pkg::S_CLR;
      end
      default: begin
        dec_next = clst_pkg::S_FIN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clst_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and memory port control
  always_comb begin
    state_d    = state_q;
    link_we    = 1'b0;
    link_waddr = tail_q;
    link_wdata = slot_q;
    link_raddr = cur_q;
    word_we    = 1'b0;
    word_raddr = cur_q;
    unique case (state_q)
      clst_pkg::S_INIT: begin
        // build the free chain: slot i links to slot i+1, last back to 0
        link_we    = 1'b1;
        link_waddr = init_q;
        link_wdata = init_last ? '0 : init_q + SLOT_W'(1);
        if (init_last) begin
          state_d = clst_pkg::S_IDLE;
        end
      end
      clst_pkg::S_IDLE: begin
        if (accept) begin
          state_d = dec_next;
        end
      end
      clst_pkg::S_WALK_REQ: begin
        link_raddr = cur_q;
        state_d    = (steps_q == '0) ? post_walk : clst_pkg::S_WALK;
      end
      clst_pkg::S_WALK: begin
        // chase the link just read, one node per cycle
        link_raddr = link_rdata;
        if (steps_q == CNT_W'(1)) begin
          state_d = post_walk;
        end
      end
      clst_pkg::S_ADD1: begin
        link_raddr = slot_q;
        word_we    = 1'b1;
        link_we    = !is_empty;
        link_waddr = (end_q == clst_pkg::E_MID) ? prev_q : tail_q;
        link_wdata = slot_q;
        state_d    = clst_pkg::S_ADD2;
      end
      clst_pkg::S_ADD2: begin
        link_we    = 1'b1;
        link_waddr = slot_q;
        if (is_empty) begin
          link_wdata = slot_q;
        end else if (end_q == clst_pkg::E_MID) begin
          link_wdata = cur_q;
        end else begin
          link_wdata = head_q;
        end
        state_d = clst_pkg::S_FIN;
      end
      clst_pkg::S_REM_A: begin
        link_raddr = rem_slot;
        word_raddr = rem_slot;
        state_d    = clst_pkg::S_REM_B;
      end
      clst_pkg::S_REM_B: begin
        // unlink the node and fetch the word of the new end
        link_we    = 1'b1;
        link_waddr = (end_q == clst_pkg::E_FRONT) ? tail_q : prev_q;
        link_wdata = (end_q == clst_pkg::E_BACK) ? head_q : link_rdata;
        word_raddr = (end_q == clst_pkg::E_FRONT) ? link_rdata : prev_q;
        state_d    = clst_pkg::S_REM_C;
      end
      clst_pkg::S_REM_C: begin
        link_we    = 1'b1;
        link_waddr = rem_slot;
        link_wdata = free_q;
        state_d    = clst_pkg::S_FIN;
      end
      clst_pkg::S_RD1: begin
        word_raddr = cur_q;
        state_d    = clst_pkg::S_RD2;
      end
      clst_pkg::S_RD2: begin
        state_d = clst_pkg::S_FIN;
      end
      clst_pkg::S_CLR: begin
        // splice the whole ring onto the free chain
        link_we    = !is_empty;
        link_waddr = tail_q;
        link_wdata = free_q;
        state_d    = clst_pkg::S_FIN;
      end
      clst_pkg::S_FIN: begin
        if (res_take_i) begin
          state_d = clst_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = clst_pkg::S_IDLE;
      end
    endcase
  end

  // list pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      free_q  <= '0;
      count_q <= '0;
    end else begin
      unique case (state_q)
        clst_pkg::S_INIT: begin
          init_q <= init_q + SLOT_W'(1);
        end
        clst_pkg::S_ADD2: begin
          free_q  <= link_rdata;
          count_q <= count_q + CNT_W'(1);
          if (is_empty) begin
            head_q <= slot_q;
            tail_q <= slot_q;
          end else if (end_q == clst_pkg::E_FRONT) begin
            head_q <= slot_q;
          end else if (end_q == clst_pkg::E_BACK) begin
            tail_q <= slot_q;
          end
        end
        clst_pkg::S_REM_C: begin
          free_q  <= rem_slot;
          count_q <= count_q - CNT_W'(1);
          if (is_single) begin
            head_q <= '0;
            tail_q <= '0;
          end else if (end_q == clst_pkg::E_FRONT) begin
            head_q <= nxt_q;
          end else if (end_q == clst_pkg::E_BACK) begin
            tail_q <= prev_q;
          end
        end
        clst_pkg::S_CLR: begin
          if (!is_empty) begin
            free_q  <= head_q;
            head_q  <= '0;
            tail_q  <= '0;
            count_q <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // per-command working registers and end words
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      clst_pkg::S_IDLE: begin
        if (accept) begin
          data_q   <= data_value_i;
          status_q <= dec_status;
          value_q  <= '0;
          kind_q   <= dec_kind;
          end_q    <= dec_end;
          slot_q   <= dec_slot;
          steps_q  <= dec_steps;
          cur_q    <= head_q;
        end
      end
      clst_pkg::S_WALK: begin
        prev_q  <= cur_q;
        cur_q   <= link_rdata;
        steps_q <= steps_q - CNT_W'(1);
      end
      clst_pkg::S_ADD2: begin
        if (is_empty) begin
          front_q <= data_q;
          back_q  <= data_q;
        end else if (end_q == clst_pkg::E_FRONT) begin
          front_q <= data_q;
        end else if (end_q == clst_pkg::E_BACK) begin
          back_q <= data_q;
        end
      end
      clst_pkg::S_REM_B: begin
        nxt_q <= link_rdata;
        if (end_q == clst_pkg::E_MID) begin
          value_q <= word_rdata;
        end
      end
      clst_pkg::S_REM_C: begin
        if (end_q == clst_pkg::E_FRONT) begin
          value_q <= front_q;
          if (!is_single) begin
            front_q <= word_rdata;
          end
        end else if (end_q == clst_pkg::E_BACK) begin
          value_q <= back_q;
          if (!is_single) begin
            back_q <= word_rdata;
          end
        end
      end
      clst_pkg::S_RD2: begin
        value_q <= word_rdata;
      end
      default: begin
      end
    endcase
  end

  clst_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (SLOT_W)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  clst_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_BITS)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (word_we),
    .waddr_i (slot_q),
    .wdata_i (data_q),
    .raddr_i (word_raddr),
    .rdata_o (word_rdata)
  );

  assign in_stall_o        = (state_q != clst_pkg::S_IDLE);
  assign res_ctrl_o.valid  = (state_q == clst_pkg::S_FIN);
  assign res_ctrl_o.status = status_q;
  assign res_value_o       = value_q;
  assign res_front_o       = is_empty ? '0 : front_q;
  assign res_back_o        = is_empty ? '0 : back_q;
  assign res_count_o       = count_q;
  assign res_empty_o       = is_empty;

endmodule

// ----- src/circular_list_store_core.sv -----
// Top level of the circular list store: sequencer plus output word register.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+--------------------------------------------
//  in      | input     | in_valid_i/in_stall_o   | command_i, position_i, data_value_i
//  out     | output    | out_valid_o/out_stall_i | status_o, value_o, front_value_o,
//          |           |                         | back_value_o, count_o, is_empty_o
//
// A failing command goes from accept straight to the result state. The others pass
// through their own states: clear, add at either end, remove at the front (a shorter
// path for the last element); insert or erase in the middle, read, and remove at the back
// of a longer list first walk the link chain one node per cycle. After reset the link memory
// is swept across all CAPACITY slots to build the free chain while in_stall_o stays high. A finished
// word waits in the output register, so the next command is taken while out_stall_i is high.
module circular_list_store_core #(
  parameter int CAPACITY = 64,
  parameter int WORD_BITS = 32,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  command_i,
  input  logic [CNT_W-1:0]            position_i,
  input  logic signed [WORD_BITS-1:0] data_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic signed [WORD_BITS-1:0] value_o,
  output logic signed [WORD_BITS-1:0] front_value_o,
  output logic signed [WORD_BITS-1:0] back_value_o,
  output logic [CNT_W-1:0]            count_o,
  output logic                        is_empty_o
);

  clst_pkg::res_ctrl_t  res_ctrl;
  logic [WORD_BITS-1:0] res_value, res_front, res_back;
  logic [CNT_W-1:0]     res_count;
  logic                 res_empty, res_take, res_load;

  clst_pkg::status_e    status_q;
  logic                 out_valid_q;
  logic [WORD_BITS-1:0] value_q, front_q, back_q;
  logic [CNT_W-1:0]     count_q;
  logic                 empty_q;

  clst_seq #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .position_i   (position_i),
    .data_value_i (data_value_i),
    .res_take_i   (res_take),
    .res_ctrl_o   (res_ctrl),
    .res_value_o  (res_value),
    .res_front_o  (res_front),
    .res_back_o   (res_back),
    .res_count_o  (res_count),
    .res_empty_o  (res_empty)
  );

  assign res_take = !out_valid_q || !out_stall_i;
  assign res_load = res_ctrl.valid && res_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_q <= res_ctrl.status;
      value_q  <= res_value;
      front_q  <= res_front;
      back_q   <= res_back;
      count_q  <= res_count;
      empty_q  <= res_empty;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign value_o       = value_q;
  assign front_value_o = front_q;
  assign back_value_o  = back_q;
  assign count_o       = count_q;
  assign is_empty_o    = empty_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ctrl.valid |-> (res_count <= CNT_W'(CAPACITY)))
    else $error("element count above capacity");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == clst_pkg::ST_FULL)) |-> (count_o == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  a_empty_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == clst_pkg::ST_EMPTY)) |-> (is_empty_o && (value_o == '0)))
    else $error("empty status on a nonempty list");

  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !res_ctrl.valid || $past(res_ctrl.valid) == 1'b0)
    else $error("result pending while a new command was taken");

endmodule
